>>> hw/rtl/cpack_pkg.sv
// shared types and constants of the c-pack line size estimator
// no dependencies

package cpack_pkg;

  localparam int MAX_LINE_WORDS = 32;
  localparam int IDX_W          = $clog2(MAX_LINE_WORDS);
  localparam int LW_W           = 6;
  localparam int BITS_W         = 11;
  localparam int CNT_W          = 6;

  localparam logic [31:0] MASK_THREE = 32'hFFFF_FF00;
  localparam logic [31:0] MASK_TWO   = 32'hFFFF_0000;

  localparam logic [5:0] COST_ZERO  = 6'd2;
  localparam logic [5:0] COST_ZZZX  = 6'd12;
  localparam logic [5:0] COST_FULL  = 6'd6;
  localparam logic [5:0] COST_THREE = 6'd16;
  localparam logic [5:0] COST_TWO   = 6'd24;
  localparam logic [5:0] COST_RAW   = 6'd34;

  localparam logic [LW_W-1:0] LINE_WORDS_RESET = LW_W'(MAX_LINE_WORDS);

  // match flags handed along the row of dictionary cells
  typedef struct packed {
    logic full;
    logic three;
    logic two;
  } hit_t;

  typedef struct packed {
    logic [CNT_W-1:0] zzzx;
    logic [CNT_W-1:0] full;
    logic [CNT_W-1:0] three;
    logic [CNT_W-1:0] two;
    logic [CNT_W-1:0] raw;
  } counts_t;

endpackage

>>> hw/rtl/cpack_if.sv
// request and result channels of the c-pack line size estimator
// depends on cpack_pkg

interface cpack_req_if;
  logic        valid;
  logic        ready;
  logic [31:0] data_word;
  logic        clear_dictionary;

  modport source (output valid, data_word, clear_dictionary, input ready);
  modport sink (input valid, data_word, clear_dictionary, output ready);
endinterface

interface cpack_res_if import cpack_pkg::*;;
  logic              valid;
  logic              ready;
  logic [BITS_W-1:0] compressed_bits;
  logic              zero_line;
  logic [CNT_W-1:0]  zero_line_words;
  logic [CNT_W-1:0]  zzzx_words;
  logic [CNT_W-1:0]  full_match_words;
  logic [CNT_W-1:0]  three_byte_match_words;
  logic [CNT_W-1:0]  two_byte_match_words;
  logic [CNT_W-1:0]  unmatched_words;

  modport source (output valid, compressed_bits, zero_line, zero_line_words, zzzx_words,
                  full_match_words, three_byte_match_words, two_byte_match_words,
                  unmatched_words, input ready);
  modport sink (input valid, compressed_bits, zero_line, zero_line_words, zzzx_words,
                full_match_words, three_byte_match_words, two_byte_match_words,
                unmatched_words, output ready);
endinterface

>>> hw/rtl/cpack_dict_cell.sv
// one dictionary entry: stored word, valid bit and its three compares
// depends on cpack_pkg

module cpack_dict_cell import cpack_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic [31:0] word,
  input  logic        clear,
  input  logic        in_use,
  input  logic        wr_en,
  input  hit_t        hit_in,
  output hit_t        hit_out
);

  logic [31:0] entry;
  logic        valid;
  logic        live;

  // a clear in the same request hides the old contents
  assign live = valid && !clear && in_use;

  assign hit_out.full  = hit_in.full  || (live && entry == word);
  assign hit_out.three = hit_in.three || (live && (entry & MASK_THREE) == (word & MASK_THREE));
  assign hit_out.two   = hit_in.two   || (live && (entry & MASK_TWO) == (word & MASK_TWO));

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
    end else if (wr_en) begin
      valid <= 1'b1;
    end else if (clear) begin
      valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      entry <= word;
    end
  end

endmodule

>>> hw/rtl/cpack_line_size_estimator.sv
// c-pack compressed size estimator, top level
// depends on cpack_pkg, cpack_req_if, cpack_res_if and cpack_dict_cell
//
// usage:
//   req carries one 32-bit word of a cache line per request, with a flag that
//   empties the dictionary before that word is classed. res carries one result
//   per line: the size in bits, saturated at line_words*32, the all-zero flag
//   and the per-class word counts. line_words (1..32, 0 acts as 1, larger
//   values as 32) sets the line length and the dictionary entries in use. The user must
//   write it via line_words_we/line_words only while no line is open (not enforced).
// timing:
//   one word per cycle. a word is classed against all entries in use of the row
//   of dictionary cells in the cycle it is accepted; the result of a line is in
//   the output register in the cycle after its last word. req stalls only while
//   a result waits and res is not ready in the same cycle.
// reset:
//   rst empties the dictionary, clears the line totals and sets line_words
//   to 32.

module cpack_line_size_estimator import cpack_pkg::*; (
  input  logic            clk,
  input  logic            rst,
  input  logic            line_words_we,
  input  logic [LW_W-1:0] line_words,
  cpack_req_if.sink       req,
  cpack_res_if.source     res
);

  logic [LW_W-1:0]   line_words_reg;
  logic [IDX_W-1:0]  replace_pointer;
  logic [BITS_W-1:0] bit_total;
  logic [LW_W-1:0]   word_position;
  logic              line_nonzero;
  counts_t           counts;

  logic [LW_W-1:0]   n;
  logic [BITS_W-1:0] limit;
  logic              accept;
  logic [31:0]       w;
  logic              is_zero;
  logic              is_zzzx;
  hit_t              hit_chain [MAX_LINE_WORDS+1];
  hit_t              hit;
  logic              insert;
  logic [IDX_W-1:0]  ins_pos;
  logic [LW_W:0]     ins_pos_inc;
  logic [IDX_W-1:0]  replace_pointer_next;
  logic [5:0]        cost;
  logic [BITS_W:0]   sum;
  logic [BITS_W-1:0] bit_total_next;
  logic [LW_W:0]     pos_inc;
  logic              last_word;
  logic              line_nonzero_next;
  counts_t           counts_next;
  logic [MAX_LINE_WORDS-1:0] wr_vec;
  logic [MAX_LINE_WORDS-1:0] use_vec;

  always_comb begin
    if (line_words_reg == '0) begin
      n = LW_W'(1);
    end else if (line_words_reg > LW_W'(MAX_LINE_WORDS)) begin
      n = LW_W'(MAX_LINE_WORDS);
    end else begin
      n = line_words_reg;
    end
  end

  assign limit     = BITS_W'(n) << 5;
  assign req.ready = !res.valid || res.ready;
  assign accept    = req.valid && req.ready;
  assign w         = req.data_word;
  assign is_zero   = (w == 32'd0);
  assign is_zzzx   = !is_zero && ((w & MASK_THREE) == 32'd0);

  assign hit_chain[0] = '0;

  for (genvar i = 0; i < MAX_LINE_WORDS; i++) begin : g_cell
    assign use_vec[i] = (LW_W'(i) < n);
    assign wr_vec[i]  = accept && insert && (ins_pos == IDX_W'(i));
    cpack_dict_cell u_cell (
      .clk     (clk),
      .rst     (rst),
      .word    (w),
      .clear   (accept && req.clear_dictionary),
      .in_use  (use_vec[i]),
      .wr_en   (wr_vec[i]),
      .hit_in  (hit_chain[i]),
      .hit_out (hit_chain[i+1])
    );
  end

  assign hit    = hit_chain[MAX_LINE_WORDS];
  assign insert = !is_zero && !is_zzzx && !hit.full && !hit.three && !hit.two;

  // insert position: restart at entry 0 after a clear or when the line shrank
  always_comb begin
    ins_pos = req.clear_dictionary ? '0 : replace_pointer;
    if (LW_W'(ins_pos) >= n) begin
      ins_pos = '0;
    end
    ins_pos_inc = (LW_W+1)'(ins_pos) + 1'b1;
    if (ins_pos_inc >= (LW_W+1)'(n)) begin
      replace_pointer_next = '0;
    end else begin
      replace_pointer_next = ins_pos_inc[IDX_W-1:0];
    end
  end

  always_comb begin
    counts_next = counts;
    priority if (is_zero) begin
      cost = COST_ZERO;
    end else if (is_zzzx) begin
      cost = COST_ZZZX;
      counts_next.zzzx = counts.zzzx + 1'b1;
    end else if (hit.full) begin
      cost = COST_FULL;
      counts_next.full = counts.full + 1'b1;
    end else if (hit.three) begin
      cost = COST_THREE;
      counts_next.three = counts.three + 1'b1;
    end else if (hit.two) begin
      cost = COST_TWO;
      counts_next.two = counts.two + 1'b1;
    end else begin
      cost = COST_RAW;
      counts_next.raw = counts.raw + 1'b1;
    end
  end

  always_comb begin
    sum            = (BITS_W+1)'(bit_total) + (BITS_W+1)'(cost);
    bit_total_next = (sum > (BITS_W+1)'(limit)) ? limit : sum[BITS_W-1:0];
  end

  assign pos_inc           = (LW_W+1)'(word_position) + 1'b1;
  assign last_word         = (pos_inc >= (LW_W+1)'(n));
  assign line_nonzero_next = line_nonzero || !is_zero;

  always_ff @(posedge clk) begin
    if (rst) begin
      line_words_reg  <= LINE_WORDS_RESET;
      replace_pointer <= '0;
      bit_total       <= '0;
      word_position   <= '0;
      line_nonzero    <= 1'b0;
      counts          <= '0;
      res.valid       <= 1'b0;
    end else begin
      if (line_words_we) begin
        line_words_reg <= line_words;
      end
      if (accept && last_word) begin
        res.valid <= 1'b1;
      end else if (res.ready) begin
        res.valid <= 1'b0;
      end
      if (accept) begin
        if (insert) begin
          replace_pointer <= replace_pointer_next;
        end else if (req.clear_dictionary) begin
          replace_pointer <= '0;
        end
        if (last_word) begin
          bit_total     <= '0;
          word_position <= '0;
          line_nonzero  <= 1'b0;
          counts        <= '0;
        end else begin
          bit_total     <= bit_total_next;
          word_position <= pos_inc[LW_W-1:0];
          line_nonzero  <= line_nonzero_next;
          counts        <= counts_next;
        end
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (accept && last_word) begin
      if (line_nonzero_next) begin
        res.compressed_bits        <= bit_total_next;
        res.zero_line              <= 1'b0;
        res.zero_line_words        <= '0;
        res.zzzx_words             <= counts_next.zzzx;
        res.full_match_words       <= counts_next.full;
        res.three_byte_match_words <= counts_next.three;
        res.two_byte_match_words   <= counts_next.two;
        res.unmatched_words        <= counts_next.raw;
      end else begin
        res.compressed_bits        <= '0;
        res.zero_line              <= 1'b1;
        res.zero_line_words        <= n;
        res.zzzx_words             <= '0;
        res.full_match_words       <= '0;
        res.three_byte_match_words <= '0;
        res.two_byte_match_words   <= '0;
        res.unmatched_words        <= '0;
      end
    end
  end

endmodule
